>>> rtl/core/tvsp_pkg.sv
// ----------------------------------------------------------------------------
// tvsp_pkg: shared types and constants of the tagged value stream parser
// Holds the item and result formats, the parser state record, the tag, role,
// kind and error codes, and the fixed payload size table.
// ----------------------------------------------------------------------------
package tvsp_pkg;

  // Nesting stack size and the widths that follow from the fixed field formats
  localparam int NEST_MAX = 32;
  localparam int DEPTH_W  = 6;
  localparam int LIMIT_W  = 6;
  localparam logic [DEPTH_W-1:0] NEST_MAX_D = DEPTH_W'(NEST_MAX);
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(32);

  // Byte roles
  localparam logic [2:0] ROLE_VERSION = 3'd0;
  localparam logic [2:0] ROLE_TAG     = 3'd1;
  localparam logic [2:0] ROLE_LENGTH  = 3'd2;
  localparam logic [2:0] ROLE_NAME    = 3'd3;
  localparam logic [2:0] ROLE_PAYLOAD = 3'd4;
  localparam logic [2:0] ROLE_CLOSE   = 3'd5;

  // Value kinds
  localparam logic [3:0] KIND_NUMBER = 4'd0;
  localparam logic [3:0] KIND_BOOL   = 4'd1;
  localparam logic [3:0] KIND_SSTR   = 4'd2;
  localparam logic [3:0] KIND_LSTR   = 4'd3;
  localparam logic [3:0] KIND_TABLE  = 4'd4;
  localparam logic [3:0] KIND_END    = 4'd5;
  localparam logic [3:0] KIND_VEC2   = 4'd6;
  localparam logic [3:0] KIND_CUSTOM = 4'd12;

  // Error codes
  localparam logic [2:0] ERR_NONE      = 3'd0;
  localparam logic [2:0] ERR_VERSION   = 3'd1;
  localparam logic [2:0] ERR_BAD_TAG   = 3'd2;
  localparam logic [2:0] ERR_MISPLACED = 3'd3;
  localparam logic [2:0] ERR_TRUNC     = 3'd4;
  localparam logic [2:0] ERR_TRAILING  = 3'd5;
  localparam logic [2:0] ERR_TOO_DEEP  = 3'd6;

  // Tag bytes with a fixed meaning
  localparam logic [7:0] TAG_NUMBER    = 8'h00;
  localparam logic [7:0] TAG_LSTR      = 8'h01;
  localparam logic [7:0] TAG_BOOL      = 8'h02;
  localparam logic [7:0] TAG_TABLE     = 8'h03;
  localparam logic [7:0] TAG_END       = 8'h04;
  localparam logic [7:0] TAG_VEC_FIRST = 8'h10;
  localparam logic [7:0] TAG_VEC_LAST  = 8'h15;

  // Payload sizes of the fixed-size kinds
  localparam logic [31:0] NUMBER_BYTES = 32'd8;
  localparam logic [31:0] BOOL_BYTES   = 32'd1;

  // Parser phase
  typedef enum logic [2:0] {
    PH_VERSION,
    PH_TAG,
    PH_LEN,
    PH_NAME,
    PH_PAYLOAD,
    PH_DONE,
    PH_ERROR
  } tvsp_phase_e;

  // One input item
  typedef struct packed {
    logic [7:0] data_byte;
    logic       buffer_last;
  } tvsp_in_t;

  // One result item
  typedef struct packed {
    logic [7:0]         byte_out;
    logic [2:0]         byte_role;
    logic [3:0]         value_kind;
    logic [DEPTH_W-1:0] nest_depth;
    logic               is_key;
    logic               value_end;
    logic               object_done;
    logic [2:0]         error_code;
  } tvsp_out_t;

  // Parser state; parity is a stack of key/value flags, bit 0 is the innermost table
  typedef struct packed {
    tvsp_phase_e         phase;
    logic [3:0]          cur_kind;
    logic [1:0]          len_idx;
    logic [31:0]         len_accum;
    logic [6:0]          name_rem;
    logic [31:0]         pay_rem;
    logic [DEPTH_W-1:0]  depth;
    logic [NEST_MAX-1:0] parity;
    logic [2:0]          sticky;
  } tvsp_state_t;

  localparam tvsp_state_t STATE_RESET = '{
    phase:     PH_VERSION,
    cur_kind:  '0,
    len_idx:   '0,
    len_accum: '0,
    name_rem:  '0,
    pay_rem:   '0,
    depth:     '0,
    parity:    '0,
    sticky:    '0
  };

  // Payload bytes of vec2, vec3, matrix, quat, vec4 and color
  function automatic logic [31:0] fixed_bytes(input logic [2:0] sel);
    logic [31:0] n;
    unique case (sel)
      3'd0:    n = 32'd16;
      3'd1:    n = 32'd24;
      3'd2:    n = 32'd128;
      3'd3:    n = 32'd32;
      3'd4:    n = 32'd32;
      3'd5:    n = 32'd16;
      default: n = 32'd0;
    endcase
    return n;
  endfunction

endpackage

>>> rtl/core/tagged_value_stream_parser.sv
// ----------------------------------------------------------------------------
// tagged_value_stream_parser: byte-wise checker and tokenizer
// Labels every byte of a serialized tagged value buffer with role, kind,
// nesting depth, key flag, end flags and an error code.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o / in_data_i) carries one buffer
//   byte per transfer, with buffer_last on the final byte. Output channel
//   (out_valid_o / out_stall_i / out_data_o) returns one labelled result per
//   input byte, in order. The cfg channel (cfg_valid_i / cfg_ready_o /
//   cfg_data_i) sets the table depth limit; write it only while idle.
//   Path: a byte taken into the input register is decoded into the result
//   register once that register is free, and transfers out from there.
//   Throughput is one byte per cycle while the receiver does not stall,
//   set by the combinational state update in the decode stage.
//   Reset clears both stages and the parser state; depth limit returns to 32.
//   When the receiver stalls, the result register holds, the next byte
//   waits in the input register, and in_stall_o rises only with both full.
//   After each buffer_last byte the parser expects a new version byte.
// ----------------------------------------------------------------------------
module tagged_value_stream_parser (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  tvsp_pkg::tvsp_in_t           in_data_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output tvsp_pkg::tvsp_out_t          out_data_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [tvsp_pkg::LIMIT_W-1:0] cfg_data_i
);
  import tvsp_pkg::*;

  logic               in_vld_q;
  tvsp_in_t           in_item_q;
  logic               out_vld_q;
  tvsp_out_t          out_q;
  tvsp_state_t        state_q;
  tvsp_state_t        state_d;
  tvsp_out_t          result_d;
  logic [LIMIT_W-1:0] limit_q;
  logic               out_free;
  logic               advance;
  logic               in_take;

  // Handshake: the result register frees when empty or taken this cycle
  assign out_free    = !out_vld_q || !out_stall_i;
  assign advance     = in_vld_q && out_free;
  assign in_stall_o  = in_vld_q && !out_free;
  assign in_take     = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;

  // Decode of the byte in the input register
  tvsp_step u_step (
    .state_i  (state_q),
    .item_i   (in_item_q),
    .limit_i  (limit_q),
    .state_o  (state_d),
    .result_o (result_d)
  );

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      state_q   <= STATE_RESET;
      limit_q   <= LIMIT_RESET;
    end else begin
      if (in_take) in_vld_q <= 1'b1;
      else if (advance) in_vld_q <= 1'b0;
      if (advance) out_vld_q <= 1'b1;
      else if (!out_stall_i) out_vld_q <= 1'b0;
      if (advance) state_q <= state_d;
      if (cfg_valid_i) limit_q <= cfg_data_i;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_take) in_item_q <= in_data_i;
    if (advance) out_q <= result_d;
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

endmodule

>>> rtl/core/tvsp_step.sv
// ----------------------------------------------------------------------------
// tvsp_step: per-byte decode and state update
// Classifies one byte against the current parser state and produces its
// labels together with the next parser state.
// ----------------------------------------------------------------------------
module tvsp_step (
  input  tvsp_pkg::tvsp_state_t     state_i,
  input  tvsp_pkg::tvsp_in_t        item_i,
  input  logic [tvsp_pkg::LIMIT_W-1:0] limit_i,
  output tvsp_pkg::tvsp_state_t     state_o,
  output tvsp_pkg::tvsp_out_t       result_o
);
  import tvsp_pkg::*;

  logic [7:0]         b;
  logic [DEPTH_W-1:0] lim;
  logic [DEPTH_W-1:0] depth_dn;
  logic               key_now;
  logic               fin;
  logic [2:0]         err;
  logic [31:0]        acc_new;
  logic [6:0]         name_nxt;
  logic [31:0]        pay_nxt;
  tvsp_state_t        st;
  tvsp_out_t          r;

  assign b        = item_i.data_byte;
  assign depth_dn = state_i.depth - DEPTH_W'(1);
  assign key_now  = (state_i.depth != '0) && !state_i.parity[0];

  // Depth limit clamped to 1..NEST_MAX
  always_comb begin
    lim = limit_i;
    if (lim == '0) lim = DEPTH_W'(1);
    if (lim > NEST_MAX_D) lim = NEST_MAX_D;
  end

  // Length field: drop the byte into its lane
  always_comb begin
    acc_new = state_i.len_accum;
    acc_new[{state_i.len_idx, 3'b000} +: 8] = b;
  end

  assign name_nxt = (state_i.name_rem != '0) ? state_i.name_rem - 7'd1 : 7'd0;
  assign pay_nxt  = (state_i.pay_rem != '0) ? state_i.pay_rem - 32'd1 : 32'd0;

  // Main decode
  always_comb begin
    st  = state_i;
    r   = '0;
    fin = 1'b0;
    err = ERR_NONE;
    r.byte_out  = b;
    r.byte_role = ROLE_PAYLOAD;

    unique case (state_i.phase)
      PH_VERSION: begin
        r.byte_role = ROLE_VERSION;
        if (b != 8'h00) err = ERR_VERSION;
        else st.phase = PH_TAG;
      end

      PH_TAG: begin
        r.byte_role  = ROLE_TAG;
        r.nest_depth = state_i.depth;
        r.is_key     = key_now;
        if (b[7] || b[6]) begin
          // custom record, compact or full form
          r.value_kind = KIND_CUSTOM;
          st.cur_kind  = KIND_CUSTOM;
          if (b[7]) begin
            st.name_rem = {4'd0, b[2:0]} + 7'd1;
            st.pay_rem  = {28'd0, b[6:3]};
            st.phase    = PH_NAME;
          end else begin
            st.name_rem  = {1'b0, b[5:0]} + 7'd1;
            st.len_idx   = '0;
            st.len_accum = '0;
            st.phase     = PH_LEN;
          end
        end else if (b[5]) begin
          // short string
          r.value_kind = KIND_SSTR;
          st.cur_kind  = KIND_SSTR;
          st.pay_rem   = {27'd0, b[4:0]};
          if (b[4:0] == 5'd0) fin = 1'b1;
          else st.phase = PH_PAYLOAD;
        end else if (b == TAG_NUMBER) begin
          r.value_kind = KIND_NUMBER;
          st.cur_kind  = KIND_NUMBER;
          st.pay_rem   = NUMBER_BYTES;
          st.phase     = PH_PAYLOAD;
        end else if (b == TAG_BOOL) begin
          r.value_kind = KIND_BOOL;
          st.cur_kind  = KIND_BOOL;
          st.pay_rem   = BOOL_BYTES;
          st.phase     = PH_PAYLOAD;
        end else if (b >= TAG_VEC_FIRST && b <= TAG_VEC_LAST) begin
          r.value_kind = KIND_VEC2 + {1'b0, b[2:0]};
          st.cur_kind  = KIND_VEC2 + {1'b0, b[2:0]};
          st.pay_rem   = fixed_bytes(b[2:0]);
          st.phase     = PH_PAYLOAD;
        end else if (b == TAG_LSTR) begin
          r.value_kind = KIND_LSTR;
          st.cur_kind  = KIND_LSTR;
          st.len_idx   = '0;
          st.len_accum = '0;
          st.phase     = PH_LEN;
        end else if (b == TAG_TABLE) begin
          // push a level, new level expects a key
          r.value_kind = KIND_TABLE;
          st.cur_kind  = KIND_TABLE;
          if (state_i.depth >= lim) begin
            err = ERR_TOO_DEEP;
          end else begin
            st.depth  = state_i.depth + DEPTH_W'(1);
            st.parity = {state_i.parity[NEST_MAX-2:0], 1'b0};
            st.phase  = PH_TAG;
          end
        end else if (b == TAG_END) begin
          // pop a level; the closed table is a finished value of its parent
          r.value_kind = KIND_END;
          st.cur_kind  = KIND_END;
          if (key_now) begin
            r.byte_role  = ROLE_CLOSE;
            r.nest_depth = depth_dn;
            r.is_key     = (depth_dn != '0) && !state_i.parity[1];
            st.depth     = depth_dn;
            st.parity    = {1'b0, state_i.parity[NEST_MAX-1:1]};
            fin          = 1'b1;
          end else begin
            err = ERR_MISPLACED;
          end
        end else begin
          err = ERR_BAD_TAG;
        end
      end

      PH_LEN: begin
        r.byte_role  = ROLE_LENGTH;
        r.value_kind = state_i.cur_kind;
        r.nest_depth = state_i.depth;
        r.is_key     = key_now;
        st.len_accum = acc_new;
        if (state_i.len_idx == 2'd3) begin
          st.len_idx = '0;
          st.pay_rem = acc_new;
          if (state_i.cur_kind == KIND_CUSTOM) st.phase = PH_NAME;
          else if (acc_new == '0) fin = 1'b1;
          else st.phase = PH_PAYLOAD;
        end else begin
          st.len_idx = state_i.len_idx + 2'd1;
        end
      end

      PH_NAME: begin
        r.byte_role  = ROLE_NAME;
        r.value_kind = state_i.cur_kind;
        r.nest_depth = state_i.depth;
        r.is_key     = key_now;
        st.name_rem  = name_nxt;
        if (name_nxt == '0) begin
          if (state_i.pay_rem == '0) fin = 1'b1;
          else st.phase = PH_PAYLOAD;
        end
      end

      PH_PAYLOAD: begin
        r.value_kind = state_i.cur_kind;
        r.nest_depth = state_i.depth;
        r.is_key     = key_now;
        st.pay_rem   = pay_nxt;
        if (pay_nxt == '0) fin = 1'b1;
      end

      PH_DONE: begin
        err = ERR_TRAILING;
      end

      default: begin
        err = (state_i.sticky != ERR_NONE) ? state_i.sticky : ERR_BAD_TAG;
      end
    endcase

    // Value finished: top level completes, else flip key/value at this level
    if (fin) begin
      r.value_end = 1'b1;
      if (st.depth == '0) begin
        st.phase      = PH_DONE;
        r.object_done = 1'b1;
      end else begin
        st.parity[0] = ~st.parity[0];
        st.phase     = PH_TAG;
      end
    end

    if (err != ERR_NONE) begin
      st.sticky = err;
      st.phase  = PH_ERROR;
    end

    // Buffer end: flag truncation and start over
    if (item_i.buffer_last) begin
      if (err == ERR_NONE && st.phase != PH_DONE) err = ERR_TRUNC;
      st = STATE_RESET;
    end

    r.error_code = err;
  end

  assign state_o  = st;
  assign result_o = r;

endmodule

>>> rtl/core/tvsp_checker.sv
// ----------------------------------------------------------------------------
// tvsp_checker: port-level checks of the tagged value stream parser
// Watches the channels of the top level over time; attached by bind.
// ----------------------------------------------------------------------------
module tvsp_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  input  logic                         in_stall_o,
  input  logic                         out_valid_o,
  input  logic                         out_stall_i,
  input  tvsp_pkg::tvsp_out_t          out_data_o
);
  import tvsp_pkg::*;

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");

  // Every accepted byte is followed by a valid result on the output
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |-> ##2 out_valid_o)
    else $error("result missing two cycles after input transfer");

  // Input backpressure only when the result register is full and stalled
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without output backpressure");

  // A new result appears only after a byte moved out of the input stage
  a_new_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> !$past(in_stall_o))
    else $error("result appeared while input stage was stalled");

endmodule

bind tagged_value_stream_parser tvsp_checker u_tvsp_checker (.*);

>>> tb/tb_tagged_value_stream_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_tagged_value_stream_parser: self-checking bench for the stream parser
// Feeds serialized buffers a byte at a time and checks every labelled result
// against a shadow parser kept in the bench. A short table of hand-picked
// bytes comes first, then generated buffers (mostly well formed, some cut,
// corrupted, padded or pure noise) under several depth limit settings, with
// random gaps on the sender and random stalls on the receiver.
// ----------------------------------------------------------------------------
module tb_tagged_value_stream_parser;
  import tvsp_pkg::*;

  // Bytes with a fixed meaning beyond the package tags
  localparam logic [7:0] VERSION_BYTE       = 8'h00;
  localparam logic [7:0] TAG_SSTR_BASE      = 8'h20;
  localparam logic [7:0] TAG_FULL_CUSTOM    = 8'h40;
  localparam logic [7:0] TAG_COMPACT_CUSTOM = 8'h80;
  localparam int VEC_BYTES [6] = '{16, 24, 128, 32, 32, 16};

  localparam int NEST_IDX_W      = $clog2(NEST_MAX);
  localparam int DRAIN_CYCLES    = 4;
  localparam int N_PHASES        = 8;
  localparam int ITEMS_PER_PHASE = 24;
  localparam int N_DIRECTED      = 23;

  // One row of the hand-written stimulus; typed rows carry their own labels
  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       typed;
    logic [2:0] role;
    logic [3:0] kind;
    logic [5:0] depth;
    logic       key;
    logic       vend;
    logic       odone;
    logic [2:0] err;
  } dir_row_t;

  localparam dir_row_t DIRECTED_ROWS [N_DIRECTED] = '{
    // version, table start, bool key, then an end mark at a value position
    '{VERSION_BYTE, 1'b0, 1'b1, ROLE_VERSION, KIND_NUMBER, 6'd0, 1'b0, 1'b0, 1'b0, ERR_NONE},
    '{TAG_TABLE, 1'b0, 1'b1, ROLE_TAG, KIND_TABLE, 6'd0, 1'b0, 1'b0, 1'b0, ERR_NONE},
    '{TAG_BOOL, 1'b0, 1'b0, ROLE_VERSION, KIND_NUMBER, 6'd0, 1'b0, 1'b0, 1'b0, ERR_NONE},
    '{8'hff, 1'b0, 1'b0, ROLE_VERSION, KIND_NUMBER, 6'd0, 1'b0, 1'b0, 1'b0, ERR_NONE},
    '{TAG_END, 1'b0, 1'b1, ROLE_TAG, KIND_END, 6'd1, 1'b0, 1'b0, 1'b0, ERR_MISPLACED},
    // bytes after an error carry the stored code
    '{8'h55, 1'b1, 1'b1, ROLE_PAYLOAD, KIND_NUMBER, 6'd0, 1'b0, 1'b0, 1'b0, ERR_MISPLACED},
    // bad version
    '{8'h07, 1'b0, 1'b1, ROLE_VERSION, KIND_NUMBER, 6'd0, 1'b0, 1'b0, 1'b0, ERR_VERSION},
    '{VERSION_BYTE, 1'b1, 1'b1, ROLE_PAYLOAD, KIND_NUMBER, 6'd0, 1'b0, 1'b0, 1'b0, ERR_VERSION},
    // compact record with a one-byte name and no payload, then trailing data
    '{VERSION_BYTE, 1'b0, 1'b0, ROLE_VERSION, KIND_NUMBER, 6'd0, 1'b0, 1'b0, 1'b0, ERR_NONE},
    '{TAG_COMPACT_CUSTOM, 1'b0, 1'b0, ROLE_VERSION, KIND_NUMBER, 6'd0, 1'b0, 1'b0, 1'b0, ERR_NONE},
    '{8'ha5, 1'b0, 1'b0, ROLE_VERSION, KIND_NUMBER, 6'd0, 1'b0, 1'b0, 1'b0, ERR_NONE},
    '{8'h00, 1'b1, 1'b1, ROLE_PAYLOAD, KIND_NUMBER, 6'd0, 1'b0, 1'b0, 1'b0, ERR_TRAILING},
    // unknown tag
    '{VERSION_BYTE, 1'b0, 1'b0, ROLE_VERSION, KIND_NUMBER, 6'd0, 1'b0, 1'b0, 1'b0, ERR_NONE},
    '{8'h05, 1'b1, 1'b1, ROLE_TAG, KIND_NUMBER, 6'd0, 1'b0, 1'b0, 1'b0, ERR_BAD_TAG},
    // full record, 64-byte name, all-ones count, cut inside the name
    '{VERSION_BYTE, 1'b0, 1'b0, ROLE_VERSION, KIND_NUMBER, 6'd0, 1'b0, 1'b0, 1'b0, ERR_NONE},
    '{TAG_FULL_CUSTOM | 8'h3f, 1'b0, 1'b0, ROLE_VERSION, KIND_NUMBER, 6'd0, 1'b0, 1'b0, 1'b0,
      ERR_NONE},
    '{8'hff, 1'b0, 1'b0, ROLE_VERSION, KIND_NUMBER, 6'd0, 1'b0, 1'b0, 1'b0, ERR_NONE},
    '{8'hff, 1'b0, 1'b0, ROLE_VERSION, KIND_NUMBER, 6'd0, 1'b0, 1'b0, 1'b0, ERR_NONE},
    '{8'hff, 1'b0, 1'b0, ROLE_VERSION, KIND_NUMBER, 6'd0, 1'b0, 1'b0, 1'b0, ERR_NONE},
    '{8'hff, 1'b0, 1'b0, ROLE_VERSION, KIND_NUMBER, 6'd0, 1'b0, 1'b0, 1'b0, ERR_NONE},
    '{8'h12, 1'b1, 1'b0, ROLE_VERSION, KIND_NUMBER, 6'd0, 1'b0, 1'b0, 1'b0, ERR_NONE},
    // empty short string completes the buffer in one tag
    '{VERSION_BYTE, 1'b0, 1'b0, ROLE_VERSION, KIND_NUMBER, 6'd0, 1'b0, 1'b0, 1'b0, ERR_NONE},
    '{TAG_SSTR_BASE, 1'b1, 1'b0, ROLE_VERSION, KIND_NUMBER, 6'd0, 1'b0, 1'b0, 1'b0, ERR_NONE}
  };

  // DUT connections
  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                in_valid_i  = 1'b0;
  logic                in_stall_o;
  tvsp_in_t            in_data_i   = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  tvsp_out_t           out_data_o;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [LIMIT_W-1:0]  cfg_data_i  = '0;

  tagged_value_stream_parser dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  // Shadow parser state
  tvsp_phase_e         ps_phase;
  logic [3:0]          ps_kind;
  logic [1:0]          ps_len_idx;
  logic [31:0]         ps_len_acc;
  logic [6:0]          ps_name_rem;
  logic [31:0]         ps_pay_rem;
  logic [DEPTH_W-1:0]  ps_depth;
  logic                ps_parity [NEST_MAX];
  logic [2:0]          ps_sticky;
  logic [LIMIT_W-1:0]  ps_limit;

  // Expected labels in transfer order, and run statistics
  tvsp_out_t pending_labels [$];
  tvsp_in_t  buf_bytes [$];
  int        fails           = 0;
  int        bytes_sent      = 0;
  int        buffers_sent    = 0;
  int        results_checked = 0;
  int        limit_writes    = 0;
  int        deepest         = 0;
  int        err_seen [8]    = '{default: 0};
  bit        steady          = 1'b0;

  // Clock
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Run limit
  initial begin
    #(5_000_000);
    $display("simulation failed");
    $finish;
  end

  // ---------------- shadow parser ----------------

  function automatic void parser_clear();
    ps_phase    = PH_VERSION;
    ps_kind     = '0;
    ps_len_idx  = '0;
    ps_len_acc  = '0;
    ps_name_rem = '0;
    ps_pay_rem  = '0;
    ps_depth    = '0;
    ps_sticky   = '0;
    for (int i = 0; i < NEST_MAX; i++) ps_parity[i] = 1'b0;
  endfunction

  // Depth limit in use: register clamped to 1..NEST_MAX
  function automatic logic [DEPTH_W-1:0] eff_limit();
    if (ps_limit == '0) return DEPTH_W'(1);
    if (ps_limit > NEST_MAX_D) return NEST_MAX_D;
    return ps_limit;
  endfunction

  // Parity slot of the innermost open table
  function automatic logic [NEST_IDX_W-1:0] top_slot();
    return NEST_IDX_W'(ps_depth - DEPTH_W'(1));
  endfunction

  function automatic logic key_now();
    if (ps_depth == '0) return 1'b0;
    return ps_parity[top_slot()] == 1'b0;
  endfunction

  // A value completed at the current depth; returns 1 at top level
  function automatic logic close_value();
    if (ps_depth == '0) begin
      ps_phase = PH_DONE;
      return 1'b1;
    end
    ps_parity[top_slot()] ^= 1'b1;
    ps_phase = PH_TAG;
    return 1'b0;
  endfunction

  // Labels one byte and advances the shadow state
  function automatic tvsp_out_t label_byte(input tvsp_in_t item);
    tvsp_out_t  r;
    logic [7:0] b;
    logic [2:0] err;
    b = item.data_byte;
    r = '0;
    r.byte_out = b;
    r.byte_role = ROLE_PAYLOAD;
    err = ERR_NONE;
    case (ps_phase)
      PH_VERSION: begin
        r.byte_role = ROLE_VERSION;
        if (b != VERSION_BYTE) err = ERR_VERSION;
        else ps_phase = PH_TAG;
      end
      PH_TAG: begin
        r.byte_role = ROLE_TAG;
        r.nest_depth = ps_depth;
        r.is_key = key_now();
        if (b[7] || b[6]) begin
          r.value_kind = KIND_CUSTOM;
          ps_kind = KIND_CUSTOM;
          if (b[7]) begin
            ps_name_rem = 7'(b[2:0]) + 7'd1;
            ps_pay_rem = 32'(b[6:3]);
            ps_phase = PH_NAME;
          end else begin
            ps_name_rem = 7'(b[5:0]) + 7'd1;
            ps_len_idx = '0;
            ps_len_acc = '0;
            ps_phase = PH_LEN;
          end
        end else if (b[5]) begin
          r.value_kind = KIND_SSTR;
          ps_kind = KIND_SSTR;
          ps_pay_rem = 32'(b[4:0]);
          if (ps_pay_rem == '0) begin
            r.value_end = 1'b1;
            r.object_done = close_value();
          end else begin
            ps_phase = PH_PAYLOAD;
          end
        end else if (b == TAG_NUMBER || b == TAG_BOOL ||
                     (b >= TAG_VEC_FIRST && b <= TAG_VEC_LAST)) begin
          if (b == TAG_NUMBER) begin
            r.value_kind = KIND_NUMBER;
            ps_pay_rem = NUMBER_BYTES;
          end else if (b == TAG_BOOL) begin
            r.value_kind = KIND_BOOL;
            ps_pay_rem = BOOL_BYTES;
          end else begin
            r.value_kind = KIND_VEC2 + 4'(b - TAG_VEC_FIRST);
            ps_pay_rem = 32'(VEC_BYTES[3'(b - TAG_VEC_FIRST)]);
          end
          ps_kind = r.value_kind;
          ps_phase = PH_PAYLOAD;
        end else if (b == TAG_LSTR) begin
          r.value_kind = KIND_LSTR;
          ps_kind = KIND_LSTR;
          ps_len_idx = '0;
          ps_len_acc = '0;
          ps_phase = PH_LEN;
        end else if (b == TAG_TABLE) begin
          r.value_kind = KIND_TABLE;
          ps_kind = KIND_TABLE;
          if (ps_depth >= eff_limit()) begin
            err = ERR_TOO_DEEP;
          end else begin
            ps_depth = ps_depth + DEPTH_W'(1);
            ps_parity[top_slot()] = 1'b0;
          end
        end else if (b == TAG_END) begin
          r.value_kind = KIND_END;
          ps_kind = KIND_END;
          if (ps_depth != '0 && ps_parity[top_slot()] == 1'b0) begin
            r.byte_role = ROLE_CLOSE;
            ps_depth = ps_depth - DEPTH_W'(1);
            r.nest_depth = ps_depth;
            r.is_key = key_now();
            r.value_end = 1'b1;
            r.object_done = close_value();
          end else begin
            err = ERR_MISPLACED;
          end
        end else begin
          err = ERR_BAD_TAG;
        end
      end
      PH_LEN: begin
        r.byte_role = ROLE_LENGTH;
        r.value_kind = ps_kind;
        r.nest_depth = ps_depth;
        r.is_key = key_now();
        ps_len_acc = ps_len_acc | (32'(b) << (8 * ps_len_idx));
        if (ps_len_idx == 2'd3) begin
          ps_len_idx = '0;
          ps_pay_rem = ps_len_acc;
          if (ps_kind == KIND_CUSTOM) begin
            ps_phase = PH_NAME;
          end else if (ps_pay_rem == '0) begin
            r.value_end = 1'b1;
            r.object_done = close_value();
          end else begin
            ps_phase = PH_PAYLOAD;
          end
        end else begin
          ps_len_idx = ps_len_idx + 2'd1;
        end
      end
      PH_NAME: begin
        r.byte_role = ROLE_NAME;
        r.value_kind = ps_kind;
        r.nest_depth = ps_depth;
        r.is_key = key_now();
        if (ps_name_rem != '0) ps_name_rem = ps_name_rem - 7'd1;
        if (ps_name_rem == '0) begin
          if (ps_pay_rem == '0) begin
            r.value_end = 1'b1;
            r.object_done = close_value();
          end else begin
            ps_phase = PH_PAYLOAD;
          end
        end
      end
      PH_PAYLOAD: begin
        r.value_kind = ps_kind;
        r.nest_depth = ps_depth;
        r.is_key = key_now();
        if (ps_pay_rem != '0) ps_pay_rem = ps_pay_rem - 32'd1;
        if (ps_pay_rem == '0) begin
          r.value_end = 1'b1;
          r.object_done = close_value();
        end
      end
      PH_DONE: err = ERR_TRAILING;
      default: err = (ps_sticky != ERR_NONE) ? ps_sticky : ERR_BAD_TAG;
    endcase

    if (err != ERR_NONE) begin
      ps_sticky = err;
      ps_phase = PH_ERROR;
    end
    // buffer end: truncation check, then back to expecting a version byte
    if (item.buffer_last) begin
      if (err == ERR_NONE && ps_phase != PH_DONE) err = ERR_TRUNC;
      parser_clear();
    end
    r.error_code = err;
    return r;
  endfunction

  // ---------------- buffer generation ----------------

  function automatic void put_byte(input logic [7:0] b);
    tvsp_in_t t;
    t.data_byte = b;
    t.buffer_last = 1'b0;
    buf_bytes.insert(buf_bytes.size(), t);
  endfunction

  function automatic void put_noise(input int n);
    for (int i = 0; i < n; i++) put_byte(8'($urandom_range(0, 255)));
  endfunction

  // 4-byte little-endian count
  function automatic void put_count(input logic [31:0] n);
    for (int i = 0; i < 4; i++) put_byte(n[8*i +: 8]);
  endfunction

  // One non-table value; tiny gives the one-byte empty string
  function automatic void put_scalar(input bit tiny);
    int n;
    int v;
    int name_len;
    if (tiny) begin
      put_byte(TAG_SSTR_BASE);
      return;
    end
    case ($urandom_range(0, 6))
      0: begin
        put_byte(TAG_NUMBER);
        put_noise(int'(NUMBER_BYTES));
      end
      1: begin
        n = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 31) : $urandom_range(0, 3);
        put_byte(TAG_SSTR_BASE | 8'(n));
        put_noise(n);
      end
      2: begin
        n = $urandom_range(0, 5);
        put_byte(TAG_LSTR);
        put_count(32'(n));
        put_noise(n);
      end
      3: begin
        // matrix kept rare, it is 128 bytes
        v = $urandom_range(0, 5);
        if (v == 2 && $urandom_range(0, 3) != 0) v = 0;
        put_byte(TAG_VEC_FIRST + 8'(v));
        put_noise(VEC_BYTES[v]);
      end
      4: begin
        name_len = $urandom_range(1, 8);
        n = $urandom_range(0, 15);
        put_byte(TAG_COMPACT_CUSTOM | 8'(n << 3) | 8'(name_len - 1));
        put_noise(name_len + n);
      end
      5: begin
        name_len = ($urandom_range(0, 7) == 0) ? 64 : $urandom_range(1, 4);
        n = $urandom_range(0, 4);
        put_byte(TAG_FULL_CUSTOM | 8'(name_len - 1));
        put_count(32'(n));
        put_noise(name_len + n);
      end
      default: begin
        put_byte(TAG_BOOL);
        put_noise(1);
      end
    endcase
  endfunction

  // Well-formed buffer; deep mode nests tables up to or just past the limit
  function automatic void build_buffer(input bit deep);
    int d;
    int target;
    int budget;
    bit gen_par [64];
    bit done;
    bit completed;
    d = 0;
    done = 1'b0;
    target = deep ? int'(eff_limit()) + $urandom_range(0, 1) : $urandom_range(0, 4);
    budget = deep ? target + $urandom_range(0, 3) : $urandom_range(1, 12);
    buf_bytes.delete();
    put_byte(VERSION_BYTE);
    while (!done) begin
      completed = 1'b0;
      if (d > 0 && !gen_par[d-1] &&
          (budget <= 0 || (!deep && $urandom_range(0, 3) == 0))) begin
        put_byte(TAG_END);
        d--;
        completed = 1'b1;
      end else if (d < target && budget > 0 && (deep || $urandom_range(0, 3) == 0)) begin
        put_byte(TAG_TABLE);
        d++;
        gen_par[d-1] = 1'b0;
        budget--;
      end else begin
        put_scalar(budget <= 0);
        budget--;
        completed = 1'b1;
      end
      if (completed) begin
        if (d == 0) done = 1'b1;
        else gen_par[d-1] = ~gen_par[d-1];
      end
    end
  endfunction

  // Broken variants: cut short, one byte corrupted, trailing bytes, noise
  function automatic void mangle_buffer();
    int k;
    case ($urandom_range(0, 3))
      0: begin
        k = $urandom_range(0, buf_bytes.size() - 1);
        while (buf_bytes.size() > k + 1) void'(buf_bytes.pop_back());
      end
      1: begin
        k = $urandom_range(0, buf_bytes.size() - 1);
        buf_bytes[k].data_byte = 8'($urandom_range(0, 255));
      end
      2: put_noise($urandom_range(1, 3));
      default: begin
        buf_bytes.delete();
        put_byte(VERSION_BYTE);
        put_noise($urandom_range(1, 8));
      end
    endcase
  endfunction

  // ---------------- drivers ----------------

  function automatic int draw_wait();
    return steady ? 0 : $urandom_range(0, 6);
  endfunction

  // One input transfer; the expectation is queued at the accepting edge
  task automatic send_byte(input tvsp_in_t item, input logic typed, input tvsp_out_t typed_want);
    int        gap;
    tvsp_out_t labels;
    gap = draw_wait();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= item;
    @(posedge clk_i);
    while (in_stall_o !== 1'b0) @(posedge clk_i);
    labels = label_byte(item);
    if (typed) labels = typed_want;
    pending_labels.insert(pending_labels.size(), labels);
    bytes_sent++;
    if (item.buffer_last) buffers_sent++;
    err_seen[labels.error_code]++;
    if (int'(labels.nest_depth) > deepest) deepest = int'(labels.nest_depth);
  endtask

  // Waits for the block to drain, then writes the depth limit
  task automatic set_depth_limit(input logic [LIMIT_W-1:0] value);
    while (pending_labels.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    cfg_data_i <= value;
    cfg_valid_i <= 1'b1;
    @(posedge clk_i);
    while (cfg_ready_o !== 1'b1) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    ps_limit = value;
    limit_writes++;
  endtask

  // Receiver may stall before each result; stall lengths are drawn by draw_wait
  initial begin : result_stall
    int n;
    @(posedge rst_ni);
    forever begin
      n = draw_wait();
      if (n > 0) begin
        out_stall_i <= 1'b1;
        repeat (n) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
      @(posedge clk_i);
      while (out_valid_o !== 1'b1) @(posedge clk_i);
    end
  end

  // ---------------- result checking ----------------

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      fails++;
    end
  endtask

  always @(posedge clk_i) begin : result_check
    tvsp_out_t want;
    if (out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
      if (pending_labels.size() == 0) begin
        $error("result transfer with nothing expected, byte_out %0h", out_data_o.byte_out);
        fails++;
      end else begin
        want = pending_labels.pop_front();
        results_checked++;
        check_field("byte_out", 32'(want.byte_out), 32'(out_data_o.byte_out));
        check_field("byte_role", 32'(want.byte_role), 32'(out_data_o.byte_role));
        check_field("value_kind", 32'(want.value_kind), 32'(out_data_o.value_kind));
        check_field("nest_depth", 32'(want.nest_depth), 32'(out_data_o.nest_depth));
        check_field("is_key", 32'(want.is_key), 32'(out_data_o.is_key));
        check_field("value_end", 32'(want.value_end), 32'(out_data_o.value_end));
        check_field("object_done", 32'(want.object_done), 32'(out_data_o.object_done));
        check_field("error_code", 32'(want.error_code), 32'(out_data_o.error_code));
      end
    end
  end

  // ---------------- main sequence ----------------

  initial begin : main_seq
    int                 phase_items;
    int                 last_idx;
    dir_row_t           row;
    tvsp_in_t           item;
    tvsp_out_t          want;
    logic [LIMIT_W-1:0] lim_val;

    ps_limit = LIMIT_RESET;
    parser_clear();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Hand-written bytes at the reset limit
    for (int i = 0; i < N_DIRECTED; i++) begin
      row = DIRECTED_ROWS[i];
      item.data_byte = row.data;
      item.buffer_last = row.last;
      want = '{byte_out: row.data, byte_role: row.role, value_kind: row.kind,
               nest_depth: row.depth, is_key: row.key, value_end: row.vend,
               object_done: row.odone, error_code: row.err};
      send_byte(item, row.typed, want);
    end
    in_valid_i <= 1'b0;

    // Generated buffers, one limit setting per phase
    for (int p = 0; p < N_PHASES; p++) begin
      case (p)
        0:       lim_val = LIMIT_W'(1);
        1:       lim_val = LIMIT_W'(63);
        2:       lim_val = LIMIT_W'(0);
        3:       lim_val = LIMIT_W'(32);
        default: lim_val = LIMIT_W'($urandom_range(0, 63));
      endcase
      set_depth_limit(lim_val);
      phase_items = 0;
      while (phase_items < ITEMS_PER_PHASE) begin
        steady = ($urandom_range(0, 4) == 0);
        build_buffer($urandom_range(0, 9) == 0);
        if ($urandom_range(0, 3) == 0) mangle_buffer();
        last_idx = buf_bytes.size() - 1;
        buf_bytes[last_idx].buffer_last = 1'b1;
        foreach (buf_bytes[i]) send_byte(buf_bytes[i], 1'b0, '0);
        phase_items += buf_bytes.size();
      end
      in_valid_i <= 1'b0;
    end

    // Drain
    steady = 1'b0;
    while (pending_labels.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (pending_labels.size() != 0) begin
      $error("%0d results never arrived", pending_labels.size());
      fails++;
    end

    $display("covered %0d bytes in %0d buffers, %0d limit writes, %0d results checked",
             bytes_sent, buffers_sent, limit_writes, results_checked);
    $display("error codes none..too deep: %0d %0d %0d %0d %0d %0d %0d, deepest nesting %0d",
             err_seen[0], err_seen[1], err_seen[2], err_seen[3], err_seen[4], err_seen[5],
             err_seen[6], deepest);
    if (fails == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
